// ===== src/euler_angles_to_rotation_matrix_top_macros.svh =====
// Assertion helpers shared by the trig stage and the top level.
`ifndef EULER_ANGLES_TO_ROTATION_MATRIX_TOP_MACROS_SVH
`define EULER_ANGLES_TO_ROTATION_MATRIX_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define EART_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define EART_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/eart_pkg.sv =====
`default_nettype none

package eart_pkg;

  // Default configuration
  localparam int ANGLE_BITS_DEF = 16;
  localparam int COEF_FRAC_DEF  = 14;
  localparam int TRIG_ITER_DEF  = 16;

  // Internal number formats: trig values are Q4.30
  localparam int WORK_FRAC = 30;
  localparam int SUM_W     = 34;
  localparam int OUT_W     = 16;
  localparam int NUM_M     = 9;

  // pi * 2^29, truncated
  localparam logic [30:0] PI_Q29 = 31'h6487ED51;

  // Sine and cosine of roll, pitch, yaw (lanes 0, 1, 2)
  typedef struct packed {
    logic                        vld;
    logic [2:0][SUM_W-1:0]       sn;
    logic [2:0][SUM_W-1:0]       cs;
  } trig_t;

  // Matrix entries, m[0] = m00 ... m[8] = m22
  typedef struct packed {
    logic                        vld;
    logic [NUM_M-1:0][OUT_W-1:0] m;
  } mat_t;

endpackage

`default_nettype wire

// ===== src/eart_in_if.sv =====
`default_nettype none

interface eart_in_if #(
  parameter int ANGLE_BITS = eart_pkg::ANGLE_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] roll_angle;
  logic signed [ANGLE_BITS-1:0] pitch_angle;
  logic signed [ANGLE_BITS-1:0] yaw_angle;

  modport source (output valid, output roll_angle, output pitch_angle, output yaw_angle,
                  input ready);
  modport sink (input valid, input roll_angle, input pitch_angle, input yaw_angle,
                output ready);
endinterface

`default_nettype wire

// ===== src/eart_out_if.sv =====
`default_nettype none

interface eart_out_if ();
  logic                               valid;
  logic                               ready;
  logic signed [eart_pkg::OUT_W-1:0]  m00;
  logic signed [eart_pkg::OUT_W-1:0]  m01;
  logic signed [eart_pkg::OUT_W-1:0]  m02;
  logic signed [eart_pkg::OUT_W-1:0]  m10;
  logic signed [eart_pkg::OUT_W-1:0]  m11;
  logic signed [eart_pkg::OUT_W-1:0]  m12;
  logic signed [eart_pkg::OUT_W-1:0]  m20;
  logic signed [eart_pkg::OUT_W-1:0]  m21;
  logic signed [eart_pkg::OUT_W-1:0]  m22;

  modport source (output valid, output m00, output m01, output m02, output m10,
                  output m11, output m12, output m20, output m21, output m22,
                  input ready);
  modport sink (input valid, input m00, input m01, input m02, input m10,
                input m11, input m12, input m20, input m21, input m22,
                output ready);
endinterface

`default_nettype wire

// ===== src/eart_trig.sv =====
`default_nettype none
`include "euler_angles_to_rotation_matrix_top_macros.svh"

// Pipelined sine/cosine for three angles: one Taylor term per two stages.
module eart_trig #(
  parameter int ANGLE_BITS      = eart_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_ITERATIONS = eart_pkg::TRIG_ITER_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [2:0][ANGLE_BITS-1:0]  ang_i,
  output eart_pkg::trig_t             trig_o
);

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  localparam int NT  = TRIG_ITERATIONS - 1;
  localparam int RW  = ANGLE_BITS - 2;
  localparam int W   = eart_pkg::WORK_FRAC;
  localparam int XW  = 31;
  localparam int TW  = 32;
  localparam int SW  = eart_pkg::SUM_W;
  localparam int NST = 2 * NT + 4;

  logic [NST-1:0] vld_q;

  // Stage X: reduced angle in radians
  logic [2:0][RW+XW-1:0] px;
  logic [2:0][XW-1:0]    x_d, x_q;
  quad_e [2:0]           qx_d, qx_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      px[l]   = (RW + XW)'(ang_i[l][RW-1:0]) * (RW + XW)'(eart_pkg::PI_Q29);
      x_d[l]  = px[l][RW +: XW];
      qx_d[l] = quad_e'(ang_i[l][ANGLE_BITS-1 -: 2]);
    end
  end

  // Stage Q: square of the angle, seed the series
  logic [2:0][2*XW-1:0] pq;
  logic [2:0][TW-1:0]   x2_d;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      pq[l]   = (2 * XW)'(x_q[l]) * (2 * XW)'(x_q[l]);
      x2_d[l] = pq[l][W +: TW];
    end
  end

  // Per-term state after each divide stage (index 0 holds the seed)
  logic [2:0][TW-1:0] tsb_q [NT+1];
  logic [2:0][TW-1:0] tcb_q [NT+1];
  logic [2:0][SW-1:0] sb_q  [NT+1];
  logic [2:0][SW-1:0] cb_q  [NT+1];
  logic [2:0][TW-1:0] x2b_q [NT+1];
  quad_e [2:0]        qb_q  [NT+1];

  // Per-term state after each multiply stage
  logic [2:0][TW-1:0] nsa_q [NT];
  logic [2:0][TW-1:0] nca_q [NT];
  logic [2:0][SW-1:0] sa_q  [NT];
  logic [2:0][SW-1:0] ca_q  [NT];
  logic [2:0][TW-1:0] x2a_q [NT];
  quad_e [2:0]        qa_q  [NT];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= x_d;
      qx_q <= qx_d;
      for (int l = 0; l < 3; l++) begin
        tsb_q[0][l] <= TW'(x_q[l]);
        tcb_q[0][l] <= TW'(1) << W;
        sb_q[0][l]  <= '0;
        cb_q[0][l]  <= '0;
      end
      x2b_q[0] <= x2_d;
      qb_q[0]  <= qx_q;
    end
  end

  for (genvar k = 1; k <= NT; k++) begin : g_term
    localparam longint unsigned DS = longint'(2 * k) * longint'(2 * k + 1);
    localparam longint unsigned DC = longint'(2 * k - 1) * longint'(2 * k);
    localparam int LS = $clog2(DS);
    localparam int LC = $clog2(DC);
    localparam longint unsigned MS = ((64'd1 << (TW + LS)) + DS - 64'd1) / DS;
    localparam longint unsigned MC = ((64'd1 << (TW + LC)) + DC - 64'd1) / DC;
    localparam logic [TW:0] MSW = (TW + 1)'(MS);
    localparam logic [TW:0] MCW = (TW + 1)'(MC);
    localparam int PSW = 2 * TW + 1 + LS;
    localparam int PCW = 2 * TW + 1 + LC;

    logic [2:0][2*TW-1:0] ps, pc;
    logic [2:0][TW-1:0]   ns_d, nc_d, ts_d, tc_d;
    logic [2:0][SW-1:0]   s_d, c_d;
    logic [2:0][PSW-1:0]  qs;
    logic [2:0][PCW-1:0]  qc;

    // Multiply by x^2, fold the previous term into the sums
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        ps[l]   = (2 * TW)'(tsb_q[k-1][l]) * (2 * TW)'(x2b_q[k-1][l]);
        pc[l]   = (2 * TW)'(tcb_q[k-1][l]) * (2 * TW)'(x2b_q[k-1][l]);
        ns_d[l] = ps[l][W +: TW];
        nc_d[l] = pc[l][W +: TW];
        if ((k % 2) == 1) begin
          s_d[l] = sb_q[k-1][l] + SW'(tsb_q[k-1][l]);
          c_d[l] = cb_q[k-1][l] + SW'(tcb_q[k-1][l]);
        end else begin
          s_d[l] = sb_q[k-1][l] - SW'(tsb_q[k-1][l]);
          c_d[l] = cb_q[k-1][l] - SW'(tcb_q[k-1][l]);
        end
      end
    end

    // Exact truncating divide by the factorial step via reciprocal multiply
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        qs[l]   = PSW'(nsa_q[k-1][l]) * PSW'(MSW);
        qc[l]   = PCW'(nca_q[k-1][l]) * PCW'(MCW);
        ts_d[l] = qs[l][TW+LS +: TW];
        tc_d[l] = qc[l][TW+LC +: TW];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nsa_q[k-1] <= ns_d;
        nca_q[k-1] <= nc_d;
        sa_q[k-1]  <= s_d;
        ca_q[k-1]  <= c_d;
        x2a_q[k-1] <= x2b_q[k-1];
        qa_q[k-1]  <= qb_q[k-1];
        tsb_q[k]   <= ts_d;
        tcb_q[k]   <= tc_d;
        sb_q[k]    <= sa_q[k-1];
        cb_q[k]    <= ca_q[k-1];
        x2b_q[k]   <= x2a_q[k-1];
        qb_q[k]    <= qa_q[k-1];
      end
    end
  end

  // Stage F1: add or subtract the last term
  logic [2:0][SW-1:0] sf_d, cf_d, sf_q, cf_q;
  quad_e [2:0]        qf_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if ((NT % 2) == 0) begin
        sf_d[l] = sb_q[NT][l] + SW'(tsb_q[NT][l]);
        cf_d[l] = cb_q[NT][l] + SW'(tcb_q[NT][l]);
      end else begin
        sf_d[l] = sb_q[NT][l] - SW'(tsb_q[NT][l]);
        cf_d[l] = cb_q[NT][l] - SW'(tcb_q[NT][l]);
      end
    end
  end

  // Stage F2: unfold the quadrant
  logic [2:0][SW-1:0] so_d, co_d, so_q, co_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      unique case (qf_q[l])
        QUAD_0: begin
          so_d[l] = sf_q[l];
          co_d[l] = cf_q[l];
        end
        QUAD_1: begin
          so_d[l] = cf_q[l];
          co_d[l] = SW'(0) - sf_q[l];
        end
        QUAD_2: begin
          so_d[l] = SW'(0) - sf_q[l];
          co_d[l] = SW'(0) - cf_q[l];
        end
        QUAD_3: begin
          so_d[l] = SW'(0) - cf_q[l];
          co_d[l] = sf_q[l];
        end
        default: begin
          so_d[l] = sf_q[l];
          co_d[l] = cf_q[l];
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sf_q <= sf_d;
      cf_q <= cf_d;
      qf_q <= qb_q[NT];
      so_q <= so_d;
      co_q <= co_d;
    end
  end

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], vld_i};
    end
  end

  assign trig_o.vld = vld_q[NST-1];
  assign trig_o.sn  = so_q;
  assign trig_o.cs  = co_q;

  `EART_ASSERT_NXT(a_trig_stall_hold, clk_i, rst_ni, !en_i, $stable(vld_q), "trig valid bits moved during stall")

endmodule

`default_nettype wire

// ===== src/eart_matrix.sv =====
`default_nettype none

// Products, sums and output rounding of the rotation matrix.
module eart_matrix #(
  parameter int COEF_FRAC_BITS = eart_pkg::COEF_FRAC_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  eart_pkg::trig_t trig_i,
  output eart_pkg::mat_t  mat_o
);

  localparam int W   = eart_pkg::WORK_FRAC;
  localparam int SW  = eart_pkg::SUM_W;
  localparam int MW  = 32;
  localparam int VW  = 35;
  localparam int RDW = 36;
  localparam int NM  = eart_pkg::NUM_M;
  localparam int OW  = eart_pkg::OUT_W;
  localparam int SH  = W - COEF_FRAC_BITS;
  localparam logic [RDW-1:0] HALF = (SH > 0) ? (RDW'(1) << (SH - 1)) : RDW'(0);
  localparam logic [RDW-1:0] LIM  = RDW'(1) << COEF_FRAC_BITS;
  localparam int NSTG = 8;

  typedef struct packed {
    logic          sg;
    logic [MW-1:0] mg;
  } sm_t;

  typedef struct packed {
    sm_t crcy, srsp, srcp, sycr, crsp, srcy, crcp, srsy, cpsy, cpcy, sp, sy, cy;
  } p1_t;

  typedef struct packed {
    sm_t a, b, c, d, crcy, sycr, srcy, srsy, srcp, crcp, cpsy, cpcy, sp;
  } p2_t;

  typedef struct packed {
    logic [VW-1:0] crcy, a, b, sycr, c, srcy, srsy, d, srcp, crcp, cpsy, nsp, cpcy;
  } p3_t;

  // Product of magnitudes truncated to Q2.30, sign from the operands
  function automatic sm_t fmul(sm_t a, sm_t b);
    logic [2*MW-1:0] p;
    sm_t             r;
    p    = (2 * MW)'(a.mg) * (2 * MW)'(b.mg);
    r.sg = a.sg ^ b.sg;
    r.mg = p[W +: MW];
    return r;
  endfunction

  function automatic logic [VW-1:0] to_val(sm_t a);
    logic [VW-1:0] e;
    e = VW'(a.mg);
    return a.sg ? VW'(0) - e : e;
  endfunction

  logic [NSTG-1:0] vld_q;

  // P0: split trig values into sign and magnitude
  sm_t [2:0] sn_d, cs_d, sn_q, cs_q;
  logic [2:0][SW-1:0] nsn, ncs;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      nsn[l]     = SW'(0) - trig_i.sn[l];
      ncs[l]     = SW'(0) - trig_i.cs[l];
      sn_d[l].sg = trig_i.sn[l][SW-1];
      cs_d[l].sg = trig_i.cs[l][SW-1];
      sn_d[l].mg = trig_i.sn[l][SW-1] ? nsn[l][MW-1:0] : trig_i.sn[l][MW-1:0];
      cs_d[l].mg = trig_i.cs[l][SW-1] ? ncs[l][MW-1:0] : trig_i.cs[l][MW-1:0];
    end
  end

  // P1: pairwise products (lane 0 roll, 1 pitch, 2 yaw)
  p1_t p1_d, p1_q;

  always_comb begin
    p1_d.crcy = fmul(cs_q[0], cs_q[2]);
    p1_d.srsp = fmul(sn_q[0], sn_q[1]);
    p1_d.srcp = fmul(sn_q[0], cs_q[1]);
    p1_d.sycr = fmul(sn_q[2], cs_q[0]);
    p1_d.crsp = fmul(cs_q[0], sn_q[1]);
    p1_d.srcy = fmul(sn_q[0], cs_q[2]);
    p1_d.crcp = fmul(cs_q[0], cs_q[1]);
    p1_d.srsy = fmul(sn_q[0], sn_q[2]);
    p1_d.cpsy = fmul(cs_q[1], sn_q[2]);
    p1_d.cpcy = fmul(cs_q[1], cs_q[2]);
    p1_d.sp   = sn_q[1];
    p1_d.sy   = sn_q[2];
    p1_d.cy   = cs_q[2];
  end

  // P2: triple products, left to right
  p2_t p2_d, p2_q;

  always_comb begin
    p2_d.a    = fmul(p1_q.srsp, p1_q.sy);
    p2_d.b    = fmul(p1_q.srsp, p1_q.cy);
    p2_d.c    = fmul(p1_q.crsp, p1_q.sy);
    p2_d.d    = fmul(p1_q.crcy, p1_q.sp);
    p2_d.crcy = p1_q.crcy;
    p2_d.sycr = p1_q.sycr;
    p2_d.srcy = p1_q.srcy;
    p2_d.srsy = p1_q.srsy;
    p2_d.srcp = p1_q.srcp;
    p2_d.crcp = p1_q.crcp;
    p2_d.cpsy = p1_q.cpsy;
    p2_d.cpcy = p1_q.cpcy;
    p2_d.sp   = p1_q.sp;
  end

  // P3: back to two's complement
  p3_t p3_d, p3_q;
  sm_t nsp;

  always_comb begin
    nsp       = p2_q.sp;
    nsp.sg    = ~p2_q.sp.sg;
    p3_d.crcy = to_val(p2_q.crcy);
    p3_d.a    = to_val(p2_q.a);
    p3_d.b    = to_val(p2_q.b);
    p3_d.sycr = to_val(p2_q.sycr);
    p3_d.c    = to_val(p2_q.c);
    p3_d.srcy = to_val(p2_q.srcy);
    p3_d.srsy = to_val(p2_q.srsy);
    p3_d.d    = to_val(p2_q.d);
    p3_d.srcp = to_val(p2_q.srcp);
    p3_d.crcp = to_val(p2_q.crcp);
    p3_d.cpsy = to_val(p2_q.cpsy);
    p3_d.nsp  = to_val(nsp);
    p3_d.cpcy = to_val(p2_q.cpcy);
  end

  // P4: matrix sums
  logic [NM-1:0][VW-1:0] sum_d, sum_q;

  always_comb begin
    sum_d[0] = p3_q.crcy + p3_q.a;
    sum_d[1] = p3_q.srcp;
    sum_d[2] = p3_q.b - p3_q.sycr;
    sum_d[3] = p3_q.c - p3_q.srcy;
    sum_d[4] = p3_q.crcp;
    sum_d[5] = p3_q.srsy + p3_q.d;
    sum_d[6] = p3_q.cpsy;
    sum_d[7] = p3_q.nsp;
    sum_d[8] = p3_q.cpcy;
  end

  // P5: magnitude
  logic [NM-1:0]         sg_d, sg5_q, sg6_q;
  logic [NM-1:0][VW-1:0] mag_d, mag_q;

  always_comb begin
    for (int i = 0; i < NM; i++) begin
      sg_d[i]  = sum_q[i][VW-1];
      mag_d[i] = sum_q[i][VW-1] ? VW'(0) - sum_q[i] : sum_q[i];
    end
  end

  // P6: round half away from zero, saturate
  logic [NM-1:0][RDW-1:0] rnd, rnd_d, rnd_q;

  always_comb begin
    for (int i = 0; i < NM; i++) begin
      rnd[i]   = (RDW'(mag_q[i]) + HALF) >> SH;
      rnd_d[i] = (rnd[i] > LIM) ? LIM : rnd[i];
    end
  end

  // P7: apply sign, keep the low output bits
  logic [NM-1:0][OW-1:0] out_d, out_q;

  always_comb begin
    for (int i = 0; i < NM; i++) begin
      out_d[i] = sg6_q[i] ? OW'(0) - rnd_q[i][OW-1:0] : rnd_q[i][OW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sn_q  <= sn_d;
      cs_q  <= cs_d;
      p1_q  <= p1_d;
      p2_q  <= p2_d;
      p3_q  <= p3_d;
      sum_q <= sum_d;
      sg5_q <= sg_d;
      mag_q <= mag_d;
      sg6_q <= sg5_q;
      rnd_q <= rnd_d;
      out_q <= out_d;
    end
  end

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-2:0], trig_i.vld};
    end
  end

  assign mat_o.vld = vld_q[NSTG-1];
  assign mat_o.m   = out_q;

endmodule

`default_nettype wire

// ===== src/euler_angles_to_rotation_matrix_top.sv =====
`default_nettype none
`include "euler_angles_to_rotation_matrix_top_macros.svh"

// Euler angles to rotation matrix. Roll, pitch and yaw enter as binary angles
// (a full turn is 2^ANGLE_BITS codes) and leave as the nine entries of the 3x3
// rotation matrix in signed fixed point with COEF_FRAC_BITS fraction bits,
// saturated to plus or minus one. The datapath is a fixed pipeline that takes
// one angle triple per clock cycle while not stalled; its stages hold the
// multipliers (series term multiply, reciprocal divide, matrix products) or
// adds. A two-entry output (pipeline register plus skid register) lets the
// input keep accepting while a result waits; the pipeline stalls only once
// the skid register is occupied.
module euler_angles_to_rotation_matrix_top #(
  parameter int ANGLE_BITS      = eart_pkg::ANGLE_BITS_DEF,
  parameter int COEF_FRAC_BITS  = eart_pkg::COEF_FRAC_DEF,
  parameter int TRIG_ITERATIONS = eart_pkg::TRIG_ITER_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  eart_in_if.sink           ang_i,
  eart_out_if.source        mat_o
);

  localparam int NM = eart_pkg::NUM_M;
  localparam int OW = eart_pkg::OUT_W;

  logic                         en;
  logic [2:0][ANGLE_BITS-1:0]   ang;
  eart_pkg::trig_t              trig;
  eart_pkg::mat_t               mres;
  logic                         sk_v_q;
  logic [NM-1:0][OW-1:0]        sk_q;
  logic [NM-1:0][OW-1:0]        res;

  // Advance the pipeline while the skid register is free
  assign en          = !sk_v_q;
  assign ang_i.ready = en;

  assign ang[0] = ANGLE_BITS'(ang_i.roll_angle);
  assign ang[1] = ANGLE_BITS'(ang_i.pitch_angle);
  assign ang[2] = ANGLE_BITS'(ang_i.yaw_angle);

  eart_trig #(
    .ANGLE_BITS      (ANGLE_BITS),
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_trig (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (ang_i.valid),
    .ang_i  (ang),
    .trig_o (trig)
  );

  eart_matrix #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_matrix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .trig_i (trig),
    .mat_o  (mres)
  );

  // Catch the last stage into the skid register when the output stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sk_v_q <= 1'b0;
    end else if (!sk_v_q && mres.vld && !mat_o.ready) begin
      sk_v_q <= 1'b1;
    end else if (sk_v_q && mat_o.ready) begin
      sk_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!sk_v_q) begin
      sk_q <= mres.m;
    end
  end

  // Present the older result first
  assign res         = sk_v_q ? sk_q : mres.m;
  assign mat_o.valid = sk_v_q || mres.vld;
  assign mat_o.m00   = res[0];
  assign mat_o.m01   = res[1];
  assign mat_o.m02   = res[2];
  assign mat_o.m10   = res[3];
  assign mat_o.m11   = res[4];
  assign mat_o.m12   = res[5];
  assign mat_o.m20   = res[6];
  assign mat_o.m21   = res[7];
  assign mat_o.m22   = res[8];

  `EART_ASSERT_NXT(a_skid_hold, clk_i, rst_ni, sk_v_q && !mat_o.ready, sk_v_q, "skid result dropped before transfer")
  `EART_ASSERT_IMP(a_skid_load, clk_i, rst_ni, $rose(sk_v_q), $past(mat_o.valid && !mat_o.ready), "skid loaded without output stall")
  `EART_ASSERT_IMP(a_m21_range, clk_i, rst_ni, mat_o.valid && (COEF_FRAC_BITS <= 14), ($signed(mat_o.m21) <= $signed(17'(1 << COEF_FRAC_BITS))) && ($signed(mat_o.m21) >= -$signed(17'(1 << COEF_FRAC_BITS))), "m21 outside unit range")

endmodule

`default_nettype wire
